// ----- hdl/sfps_pkg.sv -----
// Shared types and constants of the sensor FIFO poll sequencer.
`default_nettype none
package sfps_pkg;

   // Largest packet the sequencer will ask for in one read.
   localparam int MAX_PACKET_DEFAULT = 128;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Register reset values.
   localparam logic [7:0] PACKET_SIZE_RST    = 8'd28;
   localparam logic [7:0] POLL_INTERVAL_RST  = 8'd5;
   localparam logic [7:0] SHORT_WAIT_RST     = 8'd2;
   localparam logic [7:0] TIMEOUT_RST        = 8'd5;
   localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd104;
   localparam logic [7:0] COUNT_REG_RST      = 8'd114;
   localparam logic [7:0] DATA_REG_RST       = 8'd116;

   typedef struct packed {
      logic [7:0] packet_size;
      logic [7:0] poll_interval_ms;
      logic [7:0] short_wait_ms;
      logic [7:0] timeout_ms;
      logic [6:0] device_address;
      logic [7:0] count_reg_addr;
      logic [7:0] data_reg_addr;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        init_ok;
      logic        bus_error;
      logic        bus_done;
      logic [7:0]  bytes_avail;
      logic [15:0] count_word;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_cmd;
      logic [6:0] target_addr;
      logic [7:0] reg_pointer;
      logic [7:0] read_length;
      logic       packet_ready;
      logic       failed;
      logic [3:0] phase_out;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hdl/sfps_req_if.sv -----
// Input channel of the poll sequencer: one scheduler pass per beat.
`default_nettype none
interface sfps_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        init_ok;
   logic        bus_error;
   logic        bus_done;
   logic [7:0]  bytes_avail;
   logic [15:0] count_word;

   modport source (output valid, now_ms, init_ok, bus_error, bus_done, bytes_avail,
                   count_word, input ready);
   modport sink (input valid, now_ms, init_ok, bus_error, bus_done, bytes_avail,
                 count_word, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfps_rsp_if.sv -----
// Result channel of the poll sequencer: one bus command per beat.
`default_nettype none
interface sfps_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_cmd;
   logic [6:0] target_addr;
   logic [7:0] reg_pointer;
   logic [7:0] read_length;
   logic       packet_ready;
   logic       failed;
   logic [3:0] phase_out;

   modport source (output valid, bus_cmd, target_addr, reg_pointer, read_length,
                   packet_ready, failed, phase_out, input ready);
   modport sink (input valid, bus_cmd, target_addr, reg_pointer, read_length,
                 packet_ready, failed, phase_out, output ready);
endinterface
`default_nettype wire

// ----- hdl/sensor_fifo_poll_sequencer.sv -----
// A beat taken into the input register has its result registered when the pass advances.
// One pass per cycle unless the result channel stalls; the phase state is updated as a
// pass moves from the input register into the result register, so the next pass
// sees it at once. Reset (synchronous, active high) clears both channel stages, sets
// phase to init, zeroes the count and both timestamps, and loads the register defaults.
`default_nettype none
module sensor_fifo_poll_sequencer #(
   parameter int MaxPacket = sfps_pkg::MAX_PACKET_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   sfps_req_if.sink                           req_if,
   sfps_rsp_if.source                         rsp_if,
   input  wire                                csr_we,
   input  wire  [sfps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [sfps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   sfps_pkg::cfg_type cfg;
   sfps_pkg::req_type req_beat;
   sfps_pkg::rsp_type core_rsp;

   logic              in_vld_ff, in_vld_in;
   sfps_pkg::req_type in_data_ff;
   logic              out_vld_ff, out_vld_in;
   sfps_pkg::rsp_type out_data_ff;

   logic advance;
   logic take_in;

   assign req_beat.now_ms      = req_if.now_ms;
   assign req_beat.init_ok     = req_if.init_ok;
   assign req_beat.bus_error   = req_if.bus_error;
   assign req_beat.bus_done    = req_if.bus_done;
   assign req_beat.bytes_avail = req_if.bytes_avail;
   assign req_beat.count_word  = req_if.count_word;

   // A pass moves on when the result register is empty or is being emptied.
   assign advance       = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready  = !in_vld_ff || advance;
   assign take_in       = req_if.valid && req_if.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (take_in) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_data_ff <= req_beat;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   sfps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfps_core #(
      .MaxPacket (MaxPacket)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg),
      .req     (in_data_ff),
      .rsp     (core_rsp)
   );

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.bus_cmd      = out_data_ff.bus_cmd;
   assign rsp_if.target_addr  = out_data_ff.target_addr;
   assign rsp_if.reg_pointer  = out_data_ff.reg_pointer;
   assign rsp_if.read_length  = out_data_ff.read_length;
   assign rsp_if.packet_ready = out_data_ff.packet_ready;
   assign rsp_if.failed       = out_data_ff.failed;
   assign rsp_if.phase_out    = out_data_ff.phase_out;

endmodule
`default_nettype wire

// ----- hdl/sfps_csr.sv -----
// Configuration registers of the poll sequencer.
`default_nettype none
module sfps_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [sfps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [sfps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output sfps_pkg::cfg_type                    cfg
);

   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_PACKET_SIZE = 3'd0;
   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_POLL_INTERVAL = 3'd1;
   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_SHORT_WAIT = 3'd2;
   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_TIMEOUT = 3'd3;
   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_DEVICE_ADDRESS = 3'd4;
   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_COUNT_REG = 3'd5;
   localparam logic [sfps_pkg::CSR_INDEX_W-1:0] REG_DATA_REG = 3'd6;

   sfps_pkg::cfg_type cfg_ff;
   sfps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PACKET_SIZE:    cfg_in.packet_size = csr_wdata;
            REG_POLL_INTERVAL:  cfg_in.poll_interval_ms = csr_wdata;
            REG_SHORT_WAIT:     cfg_in.short_wait_ms = csr_wdata;
            REG_TIMEOUT:        cfg_in.timeout_ms = csr_wdata;
            REG_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata[6:0];
            REG_COUNT_REG:      cfg_in.count_reg_addr = csr_wdata;
            REG_DATA_REG:       cfg_in.data_reg_addr = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_size      <= sfps_pkg::PACKET_SIZE_RST;
         cfg_ff.poll_interval_ms <= sfps_pkg::POLL_INTERVAL_RST;
         cfg_ff.short_wait_ms    <= sfps_pkg::SHORT_WAIT_RST;
         cfg_ff.timeout_ms       <= sfps_pkg::TIMEOUT_RST;
         cfg_ff.device_address   <= sfps_pkg::DEVICE_ADDRESS_RST;
         cfg_ff.count_reg_addr   <= sfps_pkg::COUNT_REG_RST;
         cfg_ff.data_reg_addr    <= sfps_pkg::DATA_REG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/sfps_core.sv -----
// Phase machine of the poll sequencer: decides one bus command per pass.
`default_nettype none
module sfps_core #(
   parameter int MaxPacket = sfps_pkg::MAX_PACKET_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                step_en,
   input  sfps_pkg::cfg_type  cfg,
   input  sfps_pkg::req_type  req,
   output sfps_pkg::rsp_type  rsp
);

   localparam logic [3:0] PH_INIT        = 4'd0;
   localparam logic [3:0] PH_CNT_WR      = 4'd1;
   localparam logic [3:0] PH_DAT_WR      = 4'd2;
   localparam logic [3:0] PH_CNT_WR_WAIT = 4'd3;
   localparam logic [3:0] PH_DAT_WR_WAIT = 4'd4;
   localparam logic [3:0] PH_CNT_RD      = 4'd5;
   localparam logic [3:0] PH_DAT_RD      = 4'd6;
   localparam logic [3:0] PH_CNT_RD_WAIT = 4'd7;
   localparam logic [3:0] PH_DAT_RD_WAIT = 4'd8;
   localparam logic [3:0] PH_WAIT        = 4'd9;
   localparam logic [3:0] PH_WAIT_SHORT  = 4'd10;
   localparam logic [3:0] PH_FAILED      = 4'd11;

   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_INIT     = 3'd1;
   localparam logic [2:0] CMD_PTR      = 3'd2;
   localparam logic [2:0] CMD_REQ      = 3'd3;
   localparam logic [2:0] CMD_FINISH   = 3'd4;
   localparam logic [2:0] CMD_RESET    = 3'd5;
   localparam logic [2:0] CMD_TAKE_CNT = 3'd6;
   localparam logic [2:0] CMD_TAKE_PKT = 3'd7;

   localparam logic [7:0]  COUNT_LEN       = 8'd2;
   localparam logic [31:0] FAIL_RESTAMP_MS = 32'd1000;
   localparam logic [7:0]  PACKET_CAP      = 8'(MaxPacket);

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] fifo_count_ff, fifo_count_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] timeout_start_ff, timeout_start_in;

   logic [7:0]  psz;
   logic [15:0] psz_w;
   logic [31:0] since_timeout;
   logic [31:0] since_last;
   logic        timed_out;
   logic [15:0] remaining;
   logic        is_cnt;
   logic        data_in;

   always_comb begin
      if (cfg.packet_size == 8'd0) begin
         psz = 8'd1;
      end else if (cfg.packet_size > PACKET_CAP) begin
         psz = PACKET_CAP;
      end else begin
         psz = cfg.packet_size;
      end
   end

   assign psz_w         = {8'd0, psz};
   assign since_timeout = req.now_ms - timeout_start_ff;
   assign since_last    = req.now_ms - last_time_ff;
   assign timed_out     = since_timeout > {24'd0, cfg.timeout_ms};
   assign remaining     = (fifo_count_ff >= psz_w) ? (fifo_count_ff - psz_w) : 16'd0;

   always_comb begin
      phase_in         = phase_ff;
      fifo_count_in    = fifo_count_ff;
      last_time_in     = last_time_ff;
      timeout_start_in = timeout_start_ff;
      rsp              = '0;
      is_cnt           = 1'b0;
      data_in          = 1'b0;

      case (phase_ff)
         PH_INIT: begin
            rsp.bus_cmd = CMD_INIT;
            if (req.init_ok) begin
               phase_in     = PH_WAIT;
               last_time_in = req.now_ms;
            end else begin
               phase_in = PH_FAILED;
            end
         end
         PH_CNT_WR, PH_DAT_WR: begin
            is_cnt           = (phase_ff == PH_CNT_WR);
            rsp.bus_cmd      = CMD_PTR;
            rsp.target_addr  = cfg.device_address;
            rsp.reg_pointer  = is_cnt ? cfg.count_reg_addr : cfg.data_reg_addr;
            phase_in         = is_cnt ? PH_CNT_WR_WAIT : PH_DAT_WR_WAIT;
            // The write wait times out against the last poll stamp.
            timeout_start_in = last_time_ff;
         end
         PH_CNT_WR_WAIT, PH_DAT_WR_WAIT: begin
            if (req.bus_error) begin
               rsp.bus_cmd = CMD_FINISH;
               phase_in    = PH_CNT_WR;
            end else if (req.bus_done) begin
               phase_in = (phase_ff == PH_CNT_WR_WAIT) ? PH_CNT_RD : PH_DAT_RD;
            end else if (timed_out) begin
               rsp.bus_cmd = CMD_RESET;
               phase_in    = PH_CNT_WR;
            end
         end
         PH_CNT_RD, PH_DAT_RD: begin
            is_cnt           = (phase_ff == PH_CNT_RD);
            rsp.bus_cmd      = CMD_REQ;
            rsp.target_addr  = cfg.device_address;
            rsp.read_length  = is_cnt ? COUNT_LEN : psz;
            phase_in         = is_cnt ? PH_CNT_RD_WAIT : PH_DAT_RD_WAIT;
            timeout_start_in = req.now_ms;
            if (!is_cnt) begin
               last_time_in = req.now_ms;
            end
         end
         PH_CNT_RD_WAIT, PH_DAT_RD_WAIT: begin
            is_cnt  = (phase_ff == PH_CNT_RD_WAIT);
            data_in = is_cnt ? (req.bytes_avail >= COUNT_LEN) : (req.bytes_avail >= psz);
            if (req.bus_error) begin
               rsp.bus_cmd = CMD_FINISH;
               phase_in    = PH_CNT_WR;
            end else if (data_in || req.bus_done) begin
               if (is_cnt) begin
                  rsp.bus_cmd     = CMD_TAKE_CNT;
                  rsp.read_length = COUNT_LEN;
                  fifo_count_in   = req.count_word;
                  if (req.count_word >= psz_w) begin
                     phase_in = PH_DAT_WR;
                  end else begin
                     last_time_in = req.now_ms;
                     phase_in     = PH_WAIT_SHORT;
                  end
               end else begin
                  rsp.bus_cmd     = CMD_TAKE_PKT;
                  rsp.read_length = psz;
                  fifo_count_in   = remaining;
                  if (remaining >= psz_w) begin
                     phase_in = PH_DAT_WR;
                  end else begin
                     last_time_in     = req.now_ms;
                     phase_in         = PH_WAIT;
                     rsp.packet_ready = 1'b1;
                  end
               end
            end else if (timed_out) begin
               rsp.bus_cmd = CMD_RESET;
               phase_in    = PH_CNT_WR;
            end
         end
         PH_WAIT: begin
            if (since_last >= {24'd0, cfg.poll_interval_ms}) begin
               phase_in = PH_CNT_WR;
            end
         end
         PH_WAIT_SHORT: begin
            if (since_last >= {24'd0, cfg.short_wait_ms}) begin
               phase_in = PH_CNT_WR;
            end
         end
         PH_FAILED: begin
            rsp.bus_cmd = CMD_NONE;
            if (since_last >= FAIL_RESTAMP_MS) begin
               last_time_in = req.now_ms;
            end
         end
         default: begin
            phase_in = PH_CNT_WR;
         end
      endcase

      rsp.failed    = (phase_in == PH_FAILED);
      rsp.phase_out = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_INIT;
         fifo_count_ff    <= 16'd0;
         last_time_ff     <= 32'd0;
         timeout_start_ff <= 32'd0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         fifo_count_ff    <= fifo_count_in;
         last_time_ff     <= last_time_in;
         timeout_start_ff <= timeout_start_in;
      end
   end

endmodule
`default_nettype wire

// ----- tb/sfps_scoreboard_pkg.sv -----
// Phase and command codes of the poll sequencer and a scoreboard that predicts its bus commands.
package sfps_scoreboard_pkg;
   import sfps_pkg::*;

   typedef enum logic [3:0] {
      PH_INIT         = 4'd0,
      PH_CNT_PTR      = 4'd1,
      PH_DAT_PTR      = 4'd2,
      PH_CNT_PTR_WAIT = 4'd3,
      PH_DAT_PTR_WAIT = 4'd4,
      PH_CNT_REQ      = 4'd5,
      PH_DAT_REQ      = 4'd6,
      PH_CNT_RD_WAIT  = 4'd7,
      PH_DAT_RD_WAIT  = 4'd8,
      PH_POLL_WAIT    = 4'd9,
      PH_SHORT_WAIT   = 4'd10,
      PH_FAILED       = 4'd11
   } phase_e;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_INIT     = 3'd1,
      CMD_PTR      = 3'd2,
      CMD_REQ      = 3'd3,
      CMD_FINISH   = 3'd4,
      CMD_RESET    = 3'd5,
      CMD_TAKE_CNT = 3'd6,
      CMD_TAKE_PKT = 3'd7
   } cmd_e;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PACKET_SIZE    = 3'd0,
      REG_POLL_INTERVAL  = 3'd1,
      REG_SHORT_WAIT     = 3'd2,
      REG_TIMEOUT        = 3'd3,
      REG_DEVICE_ADDRESS = 3'd4,
      REG_COUNT_REG      = 3'd5,
      REG_DATA_REG       = 3'd6,
      REG_UNUSED         = 3'd7
   } reg_index_e;

   localparam int          MAX_PACKET        = MAX_PACKET_DEFAULT;
   localparam logic [2:0]  COUNT_LEN         = 3'd2;
   localparam logic [31:0] FAILED_RESTAMP_MS = 32'd1000;

   class poll_scoreboard;
      cfg_type     regs;
      logic [3:0]  phase;
      logic [15:0] fifo_count;
      logic [31:0] last_time;
      logic [31:0] timeout_start;
      rsp_type     expected_cmds[$];
      int          mismatches;

      function new();
         regs.packet_size      = PACKET_SIZE_RST;
         regs.poll_interval_ms = POLL_INTERVAL_RST;
         regs.short_wait_ms    = SHORT_WAIT_RST;
         regs.timeout_ms       = TIMEOUT_RST;
         regs.device_address   = DEVICE_ADDRESS_RST;
         regs.count_reg_addr   = COUNT_REG_RST;
         regs.data_reg_addr    = DATA_REG_RST;
         phase         = PH_INIT;
         fifo_count    = 16'd0;
         last_time     = 32'd0;
         timeout_start = 32'd0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         case (idx)
            REG_PACKET_SIZE:    regs.packet_size = val;
            REG_POLL_INTERVAL:  regs.poll_interval_ms = val;
            REG_SHORT_WAIT:     regs.short_wait_ms = val;
            REG_TIMEOUT:        regs.timeout_ms = val;
            REG_DEVICE_ADDRESS: regs.device_address = val[6:0];
            REG_COUNT_REG:      regs.count_reg_addr = val;
            REG_DATA_REG:       regs.data_reg_addr = val;
            default: ;
         endcase
      endfunction

      // A packet size of zero reads one byte, and anything above the maximum is clamped.
      function logic [7:0] packet_len();
         if (regs.packet_size == 8'd0) return 8'd1;
         if (regs.packet_size > MAX_PACKET) return 8'(MAX_PACKET);
         return regs.packet_size;
      endfunction

      function void note_pass(req_type p);
         rsp_type     r;
         logic [7:0]  psz;
         logic [31:0] since_start;
         logic [31:0] since_last;
         logic        is_cnt;
         psz = packet_len();
         since_start = p.now_ms - timeout_start;
         since_last = p.now_ms - last_time;
         r = '0;
         case (phase)
            PH_INIT: begin
               r.bus_cmd = CMD_INIT;
               if (p.init_ok) begin
                  phase = PH_POLL_WAIT;
                  last_time = p.now_ms;
               end else begin
                  phase = PH_FAILED;
               end
            end
            PH_CNT_PTR, PH_DAT_PTR: begin
               is_cnt = (phase == PH_CNT_PTR);
               r.bus_cmd = CMD_PTR;
               r.target_addr = regs.device_address;
               r.reg_pointer = is_cnt ? regs.count_reg_addr : regs.data_reg_addr;
               phase = is_cnt ? PH_CNT_PTR_WAIT : PH_DAT_PTR_WAIT;
               // The write timeout runs from the last stamp, not from this pass.
               timeout_start = last_time;
            end
            PH_CNT_PTR_WAIT, PH_DAT_PTR_WAIT: begin
               if (p.bus_error) begin
                  r.bus_cmd = CMD_FINISH;
                  phase = PH_CNT_PTR;
               end else if (p.bus_done) begin
                  phase = (phase == PH_CNT_PTR_WAIT) ? PH_CNT_REQ : PH_DAT_REQ;
               end else if (since_start > 32'(regs.timeout_ms)) begin
                  r.bus_cmd = CMD_RESET;
                  phase = PH_CNT_PTR;
               end
            end
            PH_CNT_REQ, PH_DAT_REQ: begin
               is_cnt = (phase == PH_CNT_REQ);
               r.bus_cmd = CMD_REQ;
               r.target_addr = regs.device_address;
               r.read_length = is_cnt ? 8'(COUNT_LEN) : psz;
               phase = is_cnt ? PH_CNT_RD_WAIT : PH_DAT_RD_WAIT;
               timeout_start = p.now_ms;
               if (!is_cnt) last_time = p.now_ms;
            end
            PH_CNT_RD_WAIT, PH_DAT_RD_WAIT: begin
               is_cnt = (phase == PH_CNT_RD_WAIT);
               if (p.bus_error) begin
                  r.bus_cmd = CMD_FINISH;
                  phase = PH_CNT_PTR;
               end else if ((is_cnt && p.bytes_avail >= 8'(COUNT_LEN)) ||
                            (!is_cnt && p.bytes_avail >= psz) || p.bus_done) begin
                  if (is_cnt) begin
                     r.bus_cmd = CMD_TAKE_CNT;
                     r.read_length = 8'(COUNT_LEN);
                     fifo_count = p.count_word;
                     if (fifo_count >= 16'(psz)) begin
                        phase = PH_DAT_PTR;
                     end else begin
                        last_time = p.now_ms;
                        phase = PH_SHORT_WAIT;
                     end
                  end else begin
                     r.bus_cmd = CMD_TAKE_PKT;
                     r.read_length = psz;
                     fifo_count = (fifo_count >= 16'(psz)) ? fifo_count - 16'(psz) : 16'd0;
                     if (fifo_count >= 16'(psz)) begin
                        phase = PH_DAT_PTR;
                     end else begin
                        last_time = p.now_ms;
                        phase = PH_POLL_WAIT;
                        r.packet_ready = 1'b1;
                     end
                  end
               end else if (since_start > 32'(regs.timeout_ms)) begin
                  r.bus_cmd = CMD_RESET;
                  phase = PH_CNT_PTR;
               end
            end
            PH_POLL_WAIT: begin
               if (since_last >= 32'(regs.poll_interval_ms)) phase = PH_CNT_PTR;
            end
            PH_SHORT_WAIT: begin
               if (since_last >= 32'(regs.short_wait_ms)) phase = PH_CNT_PTR;
            end
            PH_FAILED: begin
               if (since_last >= FAILED_RESTAMP_MS) last_time = p.now_ms;
            end
            default: phase = PH_CNT_PTR;
         endcase
         r.failed = (phase == PH_FAILED);
         r.phase_out = phase;
         expected_cmds.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_command(rsp_type got);
         rsp_type want;
         if (expected_cmds.size() == 0) begin
            $error("bus command beat with no pass waiting: bus_cmd %0d", got.bus_cmd);
            mismatches++;
            return;
         end
         want = expected_cmds.pop_front();
         compare_field("bus_cmd", want.bus_cmd, got.bus_cmd);
         compare_field("target_addr", want.target_addr, got.target_addr);
         compare_field("reg_pointer", want.reg_pointer, got.reg_pointer);
         compare_field("read_length", want.read_length, got.read_length);
         compare_field("packet_ready", want.packet_ready, got.packet_ready);
         compare_field("failed", want.failed, got.failed);
         compare_field("phase_out", want.phase_out, got.phase_out);
      endfunction
   endclass

endpackage

// ----- tb/sensor_fifo_poll_sequencer_tb.sv -----
// Top of the poll sequencer testbench: clock, reset, pass driver, command monitor and watchdog.
module sensor_fifo_poll_sequencer_tb;
   import sfps_pkg::*;
   import sfps_scoreboard_pkg::*;

   localparam int NUM_SETTINGS      = 8;
   localparam int PASSES_PER_SET    = 100;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT       = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [31:0] ms_clock = 32'd0;
   logic        no_idle = 1'b0;
   logic        long_hold_req = 1'b0;

   poll_scoreboard sb = new();

   sfps_req_if req_bus ();
   sfps_rsp_if rsp_bus ();

   sensor_fifo_poll_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_count(input logic [7:0] psz);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 16'(int'(psz) * $urandom_range(1, 4) + $urandom_range(0, psz - 1));
      if (roll < 70) return 16'($urandom_range(0, psz - 1));
      if (roll < 80) return 16'd0;
      if (roll < 88) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   // Builds the next pass from the predicted phase so that most passes move the
   // sequencer forward; the rest are errors, timeouts and plain noise.
   function automatic req_type next_pass();
      req_type     p;
      logic [7:0]  psz;
      logic [31:0] step;
      psz = sb.packet_len();
      p.init_ok = 1'($urandom_range(0, 1));
      p.bus_error = ($urandom_range(0, 19) == 0);
      p.bus_done = 1'b0;
      p.bytes_avail = 8'($urandom_range(0, 255));
      p.count_word = 16'($urandom_range(0, 65535));
      step = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 8) begin
         ms_clock = $urandom;
         p.bus_error = 1'($urandom_range(0, 1));
         p.bus_done = 1'($urandom_range(0, 1));
         p.now_ms = ms_clock;
         return p;
      end
      case (sb.phase)
         PH_CNT_PTR_WAIT, PH_DAT_PTR_WAIT: begin
            p.bus_done = ($urandom_range(0, 3) != 0);
            if (!p.bus_done && $urandom_range(0, 1) == 1)
               step = sb.regs.timeout_ms + $urandom_range(0, 1);
         end
         PH_CNT_RD_WAIT: begin
            p.bytes_avail = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(2, 255))
                                                        : 8'($urandom_range(0, 1));
            p.bus_done = ($urandom_range(0, 5) == 0);
            p.count_word = pick_count(psz);
            if (p.bytes_avail < 8'(COUNT_LEN) && !p.bus_done && $urandom_range(0, 1) == 1)
               step = sb.regs.timeout_ms + $urandom_range(0, 1);
         end
         PH_DAT_RD_WAIT: begin
            p.bytes_avail = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(psz, 255))
                                                        : 8'($urandom_range(0, psz - 1));
            p.bus_done = ($urandom_range(0, 5) == 0);
            if (p.bytes_avail < psz && !p.bus_done && $urandom_range(0, 1) == 1)
               step = sb.regs.timeout_ms + $urandom_range(0, 1);
         end
         PH_POLL_WAIT: begin
            if ($urandom_range(0, 2) != 0) step = sb.regs.poll_interval_ms + $urandom_range(0, 1);
         end
         PH_SHORT_WAIT: begin
            if ($urandom_range(0, 2) != 0) step = sb.regs.short_wait_ms + $urandom_range(0, 1);
         end
         default: ;
      endcase
      ms_clock = ms_clock + step;
      p.now_ms = ms_clock;
      return p;
   endfunction

   function automatic cfg_type pick_setting(input int idx);
      cfg_type c;
      c.packet_size      = 8'($urandom_range(1, 40));
      c.poll_interval_ms = 8'($urandom_range(0, 12));
      c.short_wait_ms    = 8'($urandom_range(0, 12));
      c.timeout_ms       = 8'($urandom_range(0, 12));
      c.device_address   = 7'($urandom_range(0, 127));
      c.count_reg_addr   = 8'($urandom_range(0, 255));
      c.data_reg_addr    = 8'($urandom_range(0, 255));
      case (idx)
         0: begin
            c = '0;
            c.packet_size = 8'd1;
         end
         1: c = '{8'd128, 8'd255, 8'd255, 8'd255, 7'd127, 8'd255, 8'd255};
         2: c.packet_size = 8'd0;
         3: c.packet_size = 8'd255;
         4: c.packet_size = 8'd129;
         default: ;
      endcase
      return c;
   endfunction

   // Called at a falling edge; leaves the write enable high for the caller to lower.
   task automatic write_one(input reg_index_e idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic load_settings(input cfg_type c);
      write_one(REG_PACKET_SIZE, c.packet_size);
      write_one(REG_POLL_INTERVAL, c.poll_interval_ms);
      write_one(REG_SHORT_WAIT, c.short_wait_ms);
      write_one(REG_TIMEOUT, c.timeout_ms);
      write_one(REG_DEVICE_ADDRESS, {1'($urandom_range(0, 1)), c.device_address});
      write_one(REG_COUNT_REG, c.count_reg_addr);
      write_one(REG_DATA_REG, c.data_reg_addr);
      write_one(REG_UNUSED, 8'($urandom_range(0, 255)));
      csr_we <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (sb.expected_cmds.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_pass(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.now_ms <= item.now_ms;
      req_bus.init_ok <= item.init_ok;
      req_bus.bus_error <= item.bus_error;
      req_bus.bus_done <= item.bus_done;
      req_bus.bytes_avail <= item.bytes_avail;
      req_bus.count_word <= item.count_word;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_pass(item);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [31:0] now, input logic ok, input logic err,
                              input logic done, input logic [7:0] avail,
                              input logic [15:0] cword);
      req_type p;
      p.now_ms = now;
      p.init_ok = ok;
      p.bus_error = err;
      p.bus_done = done;
      p.bytes_avail = avail;
      p.count_word = cword;
      send_pass(p);
   endtask

   always @(posedge clock) begin : result_monitor
      rsp_type got;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.bus_cmd = rsp_bus.bus_cmd;
         got.target_addr = rsp_bus.target_addr;
         got.reg_pointer = rsp_bus.reg_pointer;
         got.read_length = rsp_bus.read_length;
         got.packet_ready = rsp_bus.packet_ready;
         got.failed = rsp_bus.failed;
         got.phase_out = rsp_bus.phase_out;
         sb.check_command(got);
      end
   end

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("sensor_fifo_poll_sequencer test failed");
      $finish;
   end

   initial begin : stimulus
      req_bus.valid = 1'b0;
      req_bus.now_ms = '0;
      req_bus.init_ok = 1'b0;
      req_bus.bus_error = 1'b0;
      req_bus.bus_done = 1'b0;
      req_bus.bytes_avail = '0;
      req_bus.count_word = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Init succeeds; a failed init would park the block for the rest of the run.
      send_fields(32'd0, 1'b1, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd4, 1'b0, 1'b1, 1'b0, 8'd0, 16'd0);
      send_fields(32'd5, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd5, 1'b1, 1'b0, 1'b0, 8'd0, 16'd0);
      // The pointer write timed out from the old stamp on its very first wait.
      send_fields(32'd6, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd6, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd6, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0);
      send_fields(32'd6, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd7, 1'b0, 1'b0, 1'b0, 8'd1, 16'd0);
      send_fields(32'd7, 1'b1, 1'b0, 1'b0, 8'd255, 16'hFFFF);
      send_fields(32'd7, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd7, 1'b0, 1'b1, 1'b0, 8'd0, 16'd0);
      send_fields(32'd7, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd7, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0);
      send_fields(32'd8, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd20, 1'b0, 1'b0, 1'b0, 8'd1, 16'd0);
      send_fields(32'd20, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd20, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0);
      send_fields(32'd20, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd21, 1'b0, 1'b0, 1'b1, 8'd0, 16'd28);
      // Grow the packet past the count so the next take saturates the count at zero.
      req_bus.valid <= 1'b0;
      wait_for_results();
      write_one(REG_PACKET_SIZE, 8'd40);
      csr_we <= 1'b0;
      send_fields(32'd21, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd21, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0);
      send_fields(32'd21, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0);
      send_fields(32'd22, 1'b0, 1'b0, 1'b0, 8'd40, 16'd0);
      send_fields(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'd255, 16'hFFFF);
      ms_clock = 32'hFFFF_FFFF;

      for (int set_idx = 0; set_idx < NUM_SETTINGS; set_idx++) begin
         req_bus.valid <= 1'b0;
         wait_for_results();
         load_settings(pick_setting(set_idx));
         no_idle = (set_idx == 6);
         if (set_idx == 4) ms_clock = 32'hFFFF_FFF0;
         for (int n = 0; n < PASSES_PER_SET; n++) begin
            if (set_idx == 2 && n == 20) long_hold_req = 1'b1;
            send_pass(next_pass());
         end
      end

      req_bus.valid <= 1'b0;
      wait_for_results();
      repeat (4) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_cmds.size() == 0)
         $display("sensor_fifo_poll_sequencer test passed");
      else
         $display("sensor_fifo_poll_sequencer test failed");
      $finish;
   end

endmodule
